// ----- src/delq_pkg.sv -----
// Shared types and constants of the daily energy log queue.
package delq_pkg;

    localparam int StampW  = 32;
    localparam int EnergyW = 32;
    localparam int OffsetW = 17;
    localparam int DayW    = 17;

    localparam logic [OffsetW-1:0] OffsetReset = 17'd28800;

    // day = (t + offset) / 86400 = ((t + offset) >> 7) / 675
    localparam int DayPreShift = 7;
    localparam int RecipShift  = 36;
    localparam int RecipW      = 27;
    localparam logic [RecipW-1:0] DayRecip = 27'd101806633;

    localparam logic [1:0] CmdAdd  = 2'd0;
    localparam logic [1:0] CmdRead = 2'd1;
    localparam logic [1:0] CmdDrop = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [StampW-1:0]  entry_time;
        logic [EnergyW-1:0] energy_amount;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         entry_count;
        logic               head_valid;
        logic [StampW-1:0]  head_time;
        logic [EnergyW-1:0] head_energy;
    } out_item_t;

    typedef struct packed {
        logic [StampW-1:0]  stamp;
        logic [EnergyW-1:0] energy;
    } entry_t;

    typedef struct packed {
        logic               drop;
        logic               wr_en;
        logic [StampW-1:0]  wr_stamp;
        logic [EnergyW-1:0] wr_energy;
    } store_ctl_t;

endpackage

// ----- src/delq_day_calc.sv -----
// Day number of a timestamp: offset sum and reciprocal multiply by 1/86400.
module delq_day_calc (
    input  logic [delq_pkg::StampW-1:0]  stamp,
    input  logic [delq_pkg::OffsetW-1:0] offset,
    output logic [delq_pkg::DayW-1:0]    day
);

    localparam int SumW  = delq_pkg::StampW + 1;
    localparam int PartW = SumW - delq_pkg::DayPreShift;
    localparam int ProdW = PartW + delq_pkg::RecipW;

    logic [SumW-1:0]  sum;
    logic [PartW-1:0] part;
    logic [ProdW-1:0] prod;

    assign sum  = {1'b0, stamp} + SumW'(offset);
    assign part = sum[SumW-1:delq_pkg::DayPreShift];
    assign prod = ProdW'(part) * ProdW'(delq_pkg::DayRecip);
    assign day  = prod[delq_pkg::RecipShift +: delq_pkg::DayW];

endmodule

// ----- src/delq_log_store.sv -----
// Entry store of the log: oldest entry at slot zero, shift down on drop.
module delq_log_store #(
    parameter int LOG_DEPTH = 10
) (
    input  logic                              clk,
    input  delq_pkg::store_ctl_t              ctl,
    input  logic [$clog2(LOG_DEPTH+1)-1:0]    wr_pos,
    output delq_pkg::entry_t                  head_next
);

    localparam int CntW = $clog2(LOG_DEPTH + 1);

    delq_pkg::entry_t entry_reg  [LOG_DEPTH];
    delq_pkg::entry_t entry_next [LOG_DEPTH];

    always_comb
    begin
        for (int i = 0; i < LOG_DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        if (ctl.drop)
        begin
            for (int i = 0; i < LOG_DEPTH - 1; i++)
            begin
                entry_next[i] = entry_reg[i + 1];
            end
        end
        for (int i = 0; i < LOG_DEPTH; i++)
        begin
            if (ctl.wr_en && wr_pos == CntW'(i))
            begin
                entry_next[i].stamp  = ctl.wr_stamp;
                entry_next[i].energy = ctl.wr_energy;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LOG_DEPTH; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
    end

    assign head_next = entry_next[0];

endmodule

// ----- src/daily_energy_log_queue_core.sv -----
// Top level of the daily energy log queue: input stage, log update, result stage.
//
//   port group       direction  payload              handshake
//   in_*             in         delq_pkg::in_item_t  in_valid / in_ready
//   out_*            out        delq_pkg::out_item_t out_valid / out_ready
//   cfg_*            in         day offset, 17 bits  cfg_valid / cfg_ready
//
// One item per cycle while the result is not stalled: input register, then
// log update into the result register. The day split is one reciprocal
// multiply ahead of the input register and one on the newest entry's stamp.
// Reset empties the log and sets the day offset to 28800.
// A stalled result holds; the input register still takes one more item.
module daily_energy_log_queue_core #(
    parameter int LOG_DEPTH = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  delq_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output delq_pkg::out_item_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [delq_pkg::OffsetW-1:0]  cfg_data
);

    localparam int CntW = $clog2(LOG_DEPTH + 1);

    logic [delq_pkg::OffsetW-1:0] offset_reg;

    logic                         in_valid_reg;
    delq_pkg::in_item_t           in_item_reg;
    logic [delq_pkg::DayW-1:0]    in_day_reg;
    logic [delq_pkg::DayW-1:0]    in_day;

    logic                         out_valid_reg;
    delq_pkg::out_item_t          out_item_reg;
    delq_pkg::out_item_t          out_item_next;

    logic [CntW-1:0]              count_reg;
    logic [CntW-1:0]              count_next;
    logic [delq_pkg::StampW-1:0]  newest_stamp_reg;
    logic [delq_pkg::StampW-1:0]  newest_stamp_next;
    logic [delq_pkg::EnergyW-1:0] newest_energy_reg;
    logic [delq_pkg::EnergyW-1:0] newest_energy_next;
    logic [delq_pkg::DayW-1:0]    newest_day_reg;
    logic [delq_pkg::DayW-1:0]    newest_day_next;
    logic [delq_pkg::DayW-1:0]    newest_day_calc;

    logic                         advance;
    logic                         is_empty;
    logic                         is_full;
    logic [delq_pkg::EnergyW-1:0] merge_sum;
    logic [CntW+3:0]              count_ext;

    delq_pkg::store_ctl_t         store_ctl;
    logic [CntW-1:0]              wr_pos;
    delq_pkg::entry_t             head_next;

    delq_day_calc u_in_day (
        .stamp  (in_data.entry_time),
        .offset (offset_reg),
        .day    (in_day)
    );

    delq_day_calc u_newest_day (
        .stamp  (newest_stamp_reg),
        .offset (offset_reg),
        .day    (newest_day_calc)
    );

    delq_log_store #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_store (
        .clk       (clk),
        .ctl       (store_ctl),
        .wr_pos    (wr_pos),
        .head_next (head_next)
    );

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CntW'(LOG_DEPTH));
    assign merge_sum = newest_energy_reg + in_item_reg.energy_amount;

    always_comb
    begin
        count_next          = count_reg;
        newest_stamp_next   = newest_stamp_reg;
        newest_energy_next  = newest_energy_reg;
        newest_day_next     = newest_day_calc;
        store_ctl.drop      = 1'b0;
        store_ctl.wr_en     = 1'b0;
        store_ctl.wr_stamp  = in_item_reg.entry_time;
        store_ctl.wr_energy = in_item_reg.energy_amount;
        wr_pos              = count_reg;

        if (advance)
        begin
            case (in_item_reg.command)
                delq_pkg::CmdAdd:
                begin
                    store_ctl.wr_en = 1'b1;
                    if (is_empty)
                    begin
                        wr_pos             = '0;
                        count_next         = CntW'(1);
                        newest_stamp_next  = in_item_reg.entry_time;
                        newest_energy_next = in_item_reg.energy_amount;
                        newest_day_next    = in_day_reg;
                    end
                    else if (in_item_reg.entry_time != '0 && newest_day_reg == in_day_reg)
                    begin
                        wr_pos              = count_reg - CntW'(1);
                        store_ctl.wr_energy = merge_sum;
                        newest_stamp_next   = in_item_reg.entry_time;
                        newest_energy_next  = merge_sum;
                        newest_day_next     = in_day_reg;
                    end
                    else if (in_item_reg.entry_time == '0 || is_full)
                    begin
                        wr_pos              = count_reg - CntW'(1);
                        store_ctl.wr_stamp  = newest_stamp_reg;
                        store_ctl.wr_energy = merge_sum;
                        newest_energy_next  = merge_sum;
                    end
                    else
                    begin
                        count_next         = count_reg + CntW'(1);
                        newest_stamp_next  = in_item_reg.entry_time;
                        newest_energy_next = in_item_reg.energy_amount;
                        newest_day_next    = in_day_reg;
                    end
                end
                delq_pkg::CmdDrop:
                begin
                    if (!is_empty)
                    begin
                        store_ctl.drop = 1'b1;
                        count_next     = count_reg - CntW'(1);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign count_ext = {4'b0000, count_next};

    always_comb
    begin
        out_item_next.entry_count = count_ext[3:0];
        out_item_next.head_valid  = (count_next != '0);
        out_item_next.head_time   = '0;
        out_item_next.head_energy = '0;
        if (count_next != '0)
        begin
            out_item_next.head_time   = head_next.stamp;
            out_item_next.head_energy = head_next.energy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= delq_pkg::OffsetReset;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                offset_reg <= cfg_data;
            end
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
            in_day_reg  <= in_day;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
        newest_stamp_reg  <= newest_stamp_next;
        newest_energy_reg <= newest_energy_next;
        newest_day_reg    <= newest_day_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule
